// ===== sv/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int OUT_COUNT_BITS = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PRESSED_LEVEL   = 3'd0,
        REG_DEBOUNCE_ENABLE = 3'd1,
        REG_DEBOUNCE_TICKS  = 3'd2,
        REG_HOLD_TICKS      = 3'd3,
        REG_GAP_TICKS       = 3'd4
    } t_cfg_idx;

    localparam logic                     RST_PRESSED_LEVEL   = 1'b0;
    localparam logic                     RST_DEBOUNCE_ENABLE = 1'b1;
    localparam logic [CFG_DATA_BITS-1:0] RST_DEBOUNCE_TICKS  = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] RST_HOLD_TICKS      = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] RST_GAP_TICKS       = 16'd300;

    typedef struct packed {
        logic                     pressed_level;
        logic                     debounce_enable;
        logic [CFG_DATA_BITS-1:0] debounce_ticks;
        logic [CFG_DATA_BITS-1:0] hold_ticks;
        logic [CFG_DATA_BITS-1:0] gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                      hold_event;
        logic                      report_event;
        logic [OUT_COUNT_BITS-1:0] clicks;
        logic [OUT_COUNT_BITS-1:0] holds;
    } t_result;

endpackage

// ===== sv/bgd_intf.sv =====
// ----------------------------------------------------------------------------
// bgd_intf
// Handshake channels: button tick words, gesture result words, register writes.
// ----------------------------------------------------------------------------
interface bgd_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface bgd_out_if;
    logic                               valid;
    logic                               ready;
    logic                               hold_event;
    logic                               report_event;
    logic [bgd_pkg::OUT_COUNT_BITS-1:0] clicks;
    logic [bgd_pkg::OUT_COUNT_BITS-1:0] holds;

    modport source (output valid, output hold_event, output report_event,
                    output clicks, output holds, input ready);
    modport sink   (input valid, input hold_event, input report_event,
                    input clicks, input holds, output ready);
endinterface

interface bgd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bgd_pkg::CFG_IDX_BITS-1:0]  index;
    logic [bgd_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/button_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// button_gesture_detector
// Debounced click, multi-click and long-press detection on a sampled button.
// ----------------------------------------------------------------------------
// Every accepted tick word yields exactly one result word in the result
// register. A tick can be taken in every cycle: the whole update of timers and
// counters is one registered pass, and the result register frees itself in
// the same cycle the sink takes its word, so the only thing that slows the
// block is back-pressure on the result channel. Register writes are taken at
// any time and should only be issued while no ticks are in flight.
module button_gesture_detector #(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgd_in_if.sink     i_btn,
    bgd_cfg_if.sink    i_cfg,
    bgd_out_if.source  o_gest
);

    bgd_pkg::t_cfg    cfg;
    bgd_pkg::t_result res;
    logic             out_free;
    logic             tick_fire;

    assign i_btn.ready = out_free;
    assign tick_fire   = i_btn.valid && out_free;

    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bgd_core #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (tick_fire),
        .i_level (i_btn.button_level),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    bgd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (tick_fire),
        .i_res   (res),
        .o_free  (out_free),
        .o_gest  (o_gest)
    );

endmodule

// ===== sv/bgd_cfg.sv =====
// ----------------------------------------------------------------------------
// bgd_cfg
// Configuration register bank, written through the register write channel.
// ----------------------------------------------------------------------------
module bgd_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bgd_cfg_if.sink         i_cfg,
    output bgd_pkg::t_cfg   o_cfg
);

    bgd_pkg::t_cfg r_cfg;
    logic          wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressed_level   <= bgd_pkg::RST_PRESSED_LEVEL;
            r_cfg.debounce_enable <= bgd_pkg::RST_DEBOUNCE_ENABLE;
            r_cfg.debounce_ticks  <= bgd_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.hold_ticks      <= bgd_pkg::RST_HOLD_TICKS;
            r_cfg.gap_ticks       <= bgd_pkg::RST_GAP_TICKS;
        end else if (wr) begin
            case (bgd_pkg::t_cfg_idx'(i_cfg.index))
                bgd_pkg::REG_PRESSED_LEVEL:   r_cfg.pressed_level   <= i_cfg.data[0];
                bgd_pkg::REG_DEBOUNCE_ENABLE: r_cfg.debounce_enable <= i_cfg.data[0];
                bgd_pkg::REG_DEBOUNCE_TICKS:  r_cfg.debounce_ticks  <= i_cfg.data;
                bgd_pkg::REG_HOLD_TICKS:      r_cfg.hold_ticks      <= i_cfg.data;
                bgd_pkg::REG_GAP_TICKS:       r_cfg.gap_ticks       <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/bgd_core.sv =====
// ----------------------------------------------------------------------------
// bgd_core
// Gesture state registers and the single-pass next-state logic for one tick.
// ----------------------------------------------------------------------------
module bgd_core #(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  bgd_pkg::t_cfg    i_cfg,
    output bgd_pkg::t_result o_res
);

    localparam int OW = bgd_pkg::OUT_COUNT_BITS;
    localparam int CW = (TIMER_BITS > bgd_pkg::CFG_DATA_BITS) ? TIMER_BITS
                                                             : bgd_pkg::CFG_DATA_BITS;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic                  r_prev,     n_prev;
    logic                  r_sampled,  n_sampled;
    logic [TIMER_BITS-1:0] r_db_timer, n_db_timer;
    logic                  r_db_act,   n_db_act;
    logic [TIMER_BITS-1:0] r_hd_timer, n_hd_timer;
    logic                  r_hd_act,   n_hd_act;
    logic [TIMER_BITS-1:0] r_gp_timer, n_gp_timer;
    logic                  r_gp_act,   n_gp_act;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;
    logic [COUNT_BITS-1:0] r_clicks,   n_clicks;
    logic [COUNT_BITS-1:0] r_holds,    n_holds;
    logic                  r_locked,   n_locked;

    logic                  lvl_edge;
    logic                  pressed;
    logic                  hold_ev;
    logic                  rep;
    logic [COUNT_BITS-1:0] rc;
    logic [COUNT_BITS-1:0] rh;

    assign pressed  = (i_level == i_cfg.pressed_level);
    assign lvl_edge = (i_level != r_prev);

    always_comb begin
        n_prev     = i_level;
        n_sampled  = r_sampled;
        n_db_timer = r_db_timer;
        n_db_act   = r_db_act;
        n_hd_timer = r_hd_timer;
        n_hd_act   = r_hd_act;
        n_gp_timer = r_gp_timer;
        n_gp_act   = r_gp_act;
        n_clicks   = r_clicks;
        n_holds    = r_holds;
        n_locked   = r_locked;
        hold_ev    = 1'b0;
        rep        = 1'b0;
        rc         = '0;
        rh         = '0;

        n_elapsed = (r_elapsed != TMAX) ? r_elapsed + TIMER_BITS'(1) : r_elapsed;

        if (lvl_edge && !r_locked) begin
            n_sampled  = i_level;
            n_hd_act   = pressed;
            if (pressed) begin
                n_hd_timer = TIMER_BITS'(i_cfg.hold_ticks);
            end
            n_db_timer = i_cfg.debounce_enable ? TIMER_BITS'(i_cfg.debounce_ticks) : '0;
            n_db_act   = 1'b1;
        end

        // released while locked: let the gap run so the lock can clear
        if (r_locked && !r_gp_act && !pressed) begin
            n_gp_timer = TIMER_BITS'(i_cfg.gap_ticks);
            n_gp_act   = 1'b1;
        end

        if (n_db_act) begin
            if (n_db_timer == '0) begin
                n_db_act = 1'b0;
                if (i_cfg.debounce_enable) begin
                    if (!pressed && i_level == n_sampled) begin
                        if (CW'(n_elapsed) < CW'(i_cfg.hold_ticks)) begin
                            if (n_clicks != CMAX) n_clicks = n_clicks + COUNT_BITS'(1);
                        end else begin
                            if (n_holds != CMAX) n_holds = n_holds + COUNT_BITS'(1);
                        end
                        n_gp_timer = TIMER_BITS'(i_cfg.gap_ticks);
                        n_gp_act   = 1'b1;
                    end else begin
                        n_elapsed = '0;
                    end
                end else if (pressed) begin
                    n_locked = 1'b1;
                    rep      = 1'b1;
                    rc       = COUNT_BITS'(1);
                    rh       = '0;
                end
                n_sampled = i_level;
            end else begin
                n_db_timer = n_db_timer - TIMER_BITS'(1);
            end
        end

        if (n_hd_act) begin
            if (n_hd_timer == '0) begin
                n_hd_act = 1'b0;
                hold_ev  = pressed;
            end else begin
                n_hd_timer = n_hd_timer - TIMER_BITS'(1);
            end
        end

        if (n_gp_act) begin
            if (n_gp_timer == '0) begin
                n_gp_act = 1'b0;
                // a lone hold was already flagged, so it is not reported again
                if (i_cfg.debounce_enable &&
                    !(n_clicks == '0 && n_holds == COUNT_BITS'(1))) begin
                    rep = 1'b1;
                    rc  = n_clicks;
                    rh  = n_holds;
                end
                n_clicks = '0;
                n_holds  = '0;
                n_locked = 1'b0;
            end else begin
                n_gp_timer = n_gp_timer - TIMER_BITS'(1);
            end
        end
    end

    always_comb begin
        o_res.hold_event   = hold_ev;
        o_res.report_event = rep;
        o_res.clicks       = OW'(rc);
        o_res.holds        = OW'(rh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b1;
            r_sampled  <= 1'b1;
            r_db_timer <= '0;
            r_db_act   <= 1'b0;
            r_hd_timer <= '0;
            r_hd_act   <= 1'b0;
            r_gp_timer <= '0;
            r_gp_act   <= 1'b0;
            r_elapsed  <= '0;
            r_clicks   <= '0;
            r_holds    <= '0;
            r_locked   <= 1'b0;
        end else if (i_step) begin
            r_prev     <= n_prev;
            r_sampled  <= n_sampled;
            r_db_timer <= n_db_timer;
            r_db_act   <= n_db_act;
            r_hd_timer <= n_hd_timer;
            r_hd_act   <= n_hd_act;
            r_gp_timer <= n_gp_timer;
            r_gp_act   <= n_gp_act;
            r_elapsed  <= n_elapsed;
            r_clicks   <= n_clicks;
            r_holds    <= n_holds;
            r_locked   <= n_locked;
        end
    end

endmodule

// ===== sv/bgd_out.sv =====
// ----------------------------------------------------------------------------
// bgd_out
// Result register: holds one gesture word until the sink takes it.
// ----------------------------------------------------------------------------
module bgd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bgd_pkg::t_result i_res,
    output logic             o_free,
    bgd_out_if.source        o_gest
);

    logic             r_valid;
    bgd_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free = !r_valid || o_gest.ready;

    assign o_gest.valid        = r_valid;
    assign o_gest.hold_event   = r_res.hold_event;
    assign o_gest.report_event = r_res.report_event;
    assign o_gest.clicks       = r_res.clicks;
    assign o_gest.holds        = r_res.holds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_gest.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
